// File: sv/ipp_pkg.sv
`default_nettype none
package ipp_pkg;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] LO_BASE  = 8'h57;
    localparam logic [7:0] UP_BASE  = 8'h37;

    localparam logic [11:0] OCTET_MAX  = 12'd255;
    localparam logic [8:0]  DEC_SAT    = 9'd256;
    localparam logic [1:0]  LAST_DOT   = 2'd3;
    localparam logic [2:0]  MAX_DIGITS = 3'd4;
    localparam logic [3:0]  GROUPS     = 4'd8;
    localparam logic [3:0]  TAIL_LIMIT = 4'd7;

    localparam int FL_DIGIT   = 0;
    localparam int FL_COLON   = 1;
    localparam int FL_DCOLON  = 2;
    localparam int FL_JUST    = 3;
    localparam int FL_ANOTHER = 4;
    localparam int FL_TAIL    = 5;
    localparam logic [5:0] FL_RESET = 6'b010111;

    typedef struct packed {
        logic       step;
        logic       clear;
        logic [7:0] ch;
    } step_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] val;
        logic [1:0] dots;
        logic       seen;
        logic       wr;
    } dotted_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] addr;
    } v4_res_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] hi;
        logic [63:0] lo;
    } v6_res_t;

    function automatic dotted_t dotted_step(input logic [7:0] c, input logic [7:0] val,
                                            input logic [1:0] dots, input logic seen);
        dotted_t r;
        logic [11:0] t;
        r.ok   = 1'b0;
        r.val  = val;
        r.dots = dots;
        r.seen = seen;
        r.wr   = 1'b0;
        t = {4'd0, val} * 12'd10 + {4'd0, c - CH_0};
        if (c >= CH_0 && c <= CH_9) begin
            r.seen = 1'b1;
            if (t <= OCTET_MAX) begin
                r.ok  = 1'b1;
                r.val = t[7:0];
            end
        end else if (c == CH_DOT) begin
            if (dots != LAST_DOT) begin
                r.ok   = 1'b1;
                r.wr   = 1'b1;
                r.val  = 8'd0;
                r.dots = dots + 2'd1;
                r.seen = 1'b0;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/ipp_v4_parser.sv
`default_nettype none
module ipp_v4_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire ipp_pkg::step_t ctl,
    output ipp_pkg::v4_res_t    res
);
    logic [7:0] val_reg;
    logic [1:0] dots_reg;
    logic       seen_reg;
    logic       failed_reg;
    logic [7:0] oct_reg [0:2];
    ipp_pkg::dotted_t d;

    assign d = ipp_pkg::dotted_step(ctl.ch, val_reg, dots_reg, seen_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            val_reg    <= 8'd0;
            dots_reg   <= 2'd0;
            seen_reg   <= 1'b0;
            failed_reg <= 1'b0;
        end else if (ctl.step && !failed_reg) begin
            val_reg  <= d.val;
            dots_reg <= d.dots;
            seen_reg <= d.seen;
            if (!d.ok) begin
                failed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.step && !failed_reg && d.wr) begin
            oct_reg[dots_reg] <= val_reg;
        end
    end

    assign res.ok   = !failed_reg && seen_reg && (dots_reg == ipp_pkg::LAST_DOT);
    assign res.addr = {oct_reg[0], oct_reg[1], oct_reg[2], val_reg};
endmodule
`default_nettype wire

// File: sv/ipp_v6_parser.sv
`default_nettype none
module ipp_v6_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire ipp_pkg::step_t ctl,
    output ipp_pkg::v6_res_t    res
);
    logic [15:0] gv_reg, gv_next;
    logic [8:0]  gdec_reg, gdec_next;
    logic        letter_reg, letter_next;
    logic [2:0]  dc_reg, dc_next;
    logic [3:0]  gdone_reg, gdone_next;
    logic [3:0]  gbefore_reg, gbefore_next;
    logic [5:0]  flags_reg, flags_next;
    logic [7:0]  tval_reg, tval_next;
    logic [1:0]  tdots_reg, tdots_next;
    logic        tseen_reg, tseen_next;
    logic        failed_reg, failed_next;
    logic [15:0] store_reg [0:7];
    logic [7:0]  toct_reg [0:2];

    logic        st_wr;
    logic        to_wr;
    logic [1:0]  to_idx;
    logic [7:0]  to_data;
    logic        is_dec, is_lo, is_up;
    logic [3:0]  nib;
    logic [11:0] dsum;
    ipp_pkg::dotted_t d;
    logic [7:0]  c;

    assign c      = ctl.ch;
    assign is_dec = c >= ipp_pkg::CH_0 && c <= ipp_pkg::CH_9;
    assign is_lo  = c >= ipp_pkg::CH_LA && c <= ipp_pkg::CH_LF;
    assign is_up  = c >= ipp_pkg::CH_UA && c <= ipp_pkg::CH_UF;
    assign d      = ipp_pkg::dotted_step(c, tval_reg, tdots_reg, tseen_reg);
    assign dsum   = {3'd0, gdec_reg} * 12'd10 + {8'd0, nib};

    always_comb begin
        logic [7:0] diff;
        if (is_lo) begin
            diff = c - ipp_pkg::LO_BASE;
        end else if (is_up) begin
            diff = c - ipp_pkg::UP_BASE;
        end else begin
            diff = c - ipp_pkg::CH_0;
        end
        nib = diff[3:0];
    end

    always_comb begin
        gv_next      = gv_reg;
        gdec_next    = gdec_reg;
        letter_next  = letter_reg;
        dc_next      = dc_reg;
        gdone_next   = gdone_reg;
        gbefore_next = gbefore_reg;
        flags_next   = flags_reg;
        tval_next    = tval_reg;
        tdots_next   = tdots_reg;
        tseen_next   = tseen_reg;
        failed_next  = failed_reg;
        st_wr        = 1'b0;
        to_wr        = 1'b0;
        to_idx       = tdots_reg;
        to_data      = tval_reg;
        if (ctl.step && !failed_reg) begin
            if (flags_reg[ipp_pkg::FL_TAIL]) begin
                tval_next  = d.val;
                tdots_next = d.dots;
                tseen_next = d.seen;
                to_wr      = d.wr;
                if (!d.ok) begin
                    failed_next = 1'b1;
                end
            end else if (is_dec || is_lo || is_up) begin
                if (!flags_reg[ipp_pkg::FL_DIGIT] || dc_reg >= ipp_pkg::MAX_DIGITS) begin
                    failed_next = 1'b1;
                end else begin
                    dc_next = dc_reg + 3'd1;
                    flags_next[ipp_pkg::FL_COLON] = 1'b1;
                    flags_next[ipp_pkg::FL_JUST]  = 1'b0;
                    gv_next = {gv_reg[11:0], nib};
                    if (is_dec) begin
                        gdec_next = (dsum > ipp_pkg::OCTET_MAX) ? ipp_pkg::DEC_SAT : dsum[8:0];
                    end else begin
                        letter_next = 1'b1;
                    end
                end
            end else if (c == ipp_pkg::CH_COLON) begin
                if (!flags_reg[ipp_pkg::FL_COLON]) begin
                    failed_next = 1'b1;
                end else if (flags_reg[ipp_pkg::FL_JUST]) begin
                    flags_next[ipp_pkg::FL_DIGIT]   = 1'b1;
                    flags_next[ipp_pkg::FL_COLON]   = 1'b0;
                    flags_next[ipp_pkg::FL_ANOTHER] = 1'b0;
                    flags_next[ipp_pkg::FL_DCOLON]  = 1'b0;
                    gbefore_next = gdone_reg;
                end else if (gdone_reg >= ipp_pkg::GROUPS) begin
                    failed_next = 1'b1;
                end else if (dc_reg == 3'd0 && gdone_reg == 4'd0) begin
                    flags_next[ipp_pkg::FL_COLON]   = 1'b1;
                    flags_next[ipp_pkg::FL_JUST]    = 1'b1;
                    flags_next[ipp_pkg::FL_ANOTHER] = 1'b1;
                    flags_next[ipp_pkg::FL_DIGIT]   = 1'b0;
                end else begin
                    st_wr       = 1'b1;
                    gdone_next  = gdone_reg + 4'd1;
                    gv_next     = 16'd0;
                    gdec_next   = 9'd0;
                    letter_next = 1'b0;
                    dc_next     = 3'd0;
                    flags_next[ipp_pkg::FL_COLON]   = flags_reg[ipp_pkg::FL_DCOLON];
                    flags_next[ipp_pkg::FL_JUST]    = 1'b1;
                    flags_next[ipp_pkg::FL_ANOTHER] = 1'b1;
                end
            end else if (c == ipp_pkg::CH_DOT) begin
                if (gdone_reg >= ipp_pkg::TAIL_LIMIT || letter_reg
                    || gdec_reg > ipp_pkg::OCTET_MAX[8:0]) begin
                    failed_next = 1'b1;
                end else begin
                    to_wr      = 1'b1;
                    to_idx     = 2'd0;
                    to_data    = gdec_reg[7:0];
                    tdots_next = 2'd1;
                    tval_next  = 8'd0;
                    tseen_next = 1'b0;
                    flags_next[ipp_pkg::FL_TAIL] = 1'b1;
                end
            end else begin
                failed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            gv_reg      <= 16'd0;
            gdec_reg    <= 9'd0;
            letter_reg  <= 1'b0;
            dc_reg      <= 3'd0;
            gdone_reg   <= 4'd0;
            gbefore_reg <= 4'd0;
            flags_reg   <= ipp_pkg::FL_RESET;
            tval_reg    <= 8'd0;
            tdots_reg   <= 2'd0;
            tseen_reg   <= 1'b0;
            failed_reg  <= 1'b0;
        end else begin
            gv_reg      <= gv_next;
            gdec_reg    <= gdec_next;
            letter_reg  <= letter_next;
            dc_reg      <= dc_next;
            gdone_reg   <= gdone_next;
            gbefore_reg <= gbefore_next;
            flags_reg   <= flags_next;
            tval_reg    <= tval_next;
            tdots_reg   <= tdots_next;
            tseen_reg   <= tseen_next;
            failed_reg  <= failed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_wr) begin
            store_reg[gdone_reg[2:0]] <= gv_reg;
        end
        if (to_wr && to_idx != ipp_pkg::LAST_DOT) begin
            toct_reg[to_idx] <= to_data;
        end
    end

    always_comb begin
        logic         tail;
        logic         fail;
        logic         gap;
        logic [3:0]   gd;
        logic [3:0]   after;
        logic [15:0]  t0;
        logic [15:0]  t1;
        logic [127:0] s_vec;
        logic [255:0] rot;
        logic [15:0]  g [0:7];
        tail  = flags_reg[ipp_pkg::FL_TAIL];
        gap   = !flags_reg[ipp_pkg::FL_DCOLON];
        t0    = {toct_reg[0], toct_reg[1]};
        t1    = {toct_reg[2], tval_reg};
        for (int i = 0; i < 8; i++) begin
            s_vec[i*16 +: 16] = store_reg[i];
            if (tail) begin
                if (4'(i) == gdone_reg) begin
                    s_vec[i*16 +: 16] = t0;
                end
                if (4'(i) == gdone_reg + 4'd1) begin
                    s_vec[i*16 +: 16] = t1;
                end
            end else if (dc_reg != 3'd0 && 4'(i) == gdone_reg) begin
                s_vec[i*16 +: 16] = gv_reg;
            end
        end
        if (tail) begin
            gd = gdone_reg + 4'd2;
        end else if (dc_reg != 3'd0) begin
            gd = gdone_reg + 4'd1;
        end else begin
            gd = gdone_reg;
        end
        fail = failed_reg;
        if (tail && (!tseen_reg || tdots_reg != ipp_pkg::LAST_DOT)) begin
            fail = 1'b1;
        end
        if (!tail && dc_reg != 3'd0 && gdone_reg >= ipp_pkg::GROUPS) begin
            fail = 1'b1;
        end
        if (!tail && dc_reg == 3'd0 && flags_reg[ipp_pkg::FL_ANOTHER]) begin
            fail = 1'b1;
        end
        if (gd > ipp_pkg::GROUPS) begin
            fail = 1'b1;
        end
        if (gap && gbefore_reg > gd) begin
            fail = 1'b1;
        end
        if (!gap && gd != ipp_pkg::GROUPS) begin
            fail = 1'b1;
        end
        after = gd - gbefore_reg;
        rot   = {s_vec, s_vec} >> {gd[2:0], 4'd0};
        for (int i = 0; i < 8; i++) begin
            if (!gap || 4'(i) < gbefore_reg) begin
                g[i] = s_vec[i*16 +: 16];
            end else if (4'(i) >= ipp_pkg::GROUPS - after) begin
                g[i] = rot[i*16 +: 16];
            end else begin
                g[i] = 16'd0;
            end
        end
        res.ok = !fail;
        res.hi = {g[0], g[1], g[2], g[3]};
        res.lo = {g[4], g[5], g[6], g[7]};
    end
endmodule
`default_nettype wire

// File: sv/ip_address_text_parser.sv
// A result beat is registered into the output register when its terminator beat is consumed.
// Throughput: one character beat per cycle while no terminator waits; each updates the parsers as it is consumed.
// A waiting result does not block characters; only a second terminator waits for it.
// Reset: synchronous active-low aresetn clears both parsers and the input and output valid flags.
// Each result returns both parsers to their reset state.
`default_nettype none
module ip_address_text_parser (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,  // text_char, port_value
    input  wire logic         s_tlast,  // end_of_text
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata,  // address_high, address_low, port_out
    output logic [1:0]        m_tuser   // parse_ok, is_ipv6
);
    logic         in_valid_reg;
    logic [7:0]   in_char_reg;
    logic         in_last_reg;
    logic [15:0]  in_port_reg;
    logic         out_valid_reg;
    logic [143:0] out_data_reg;
    logic [1:0]   out_user_reg;
    logic         consume;
    ipp_pkg::step_t   ctl;
    ipp_pkg::v4_res_t v4_res;
    ipp_pkg::v6_res_t v6_res;

    assign consume  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    assign ctl.step  = consume && !in_last_reg;
    assign ctl.clear = consume && in_last_reg;
    assign ctl.ch    = in_char_reg;

    ipp_v4_parser u_v4 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .res     (v4_res)
    );

    ipp_v6_parser u_v6 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .res     (v6_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_char_reg <= s_tdata[7:0];
            in_port_reg <= s_tdata[23:8];
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.clear) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            if (v4_res.ok) begin
                out_user_reg <= 2'b01;
                out_data_reg <= {in_port_reg, 32'd0, v4_res.addr, 64'd0};
            end else if (v6_res.ok) begin
                out_user_reg <= 2'b11;
                out_data_reg <= {in_port_reg, v6_res.lo, v6_res.hi};
            end else begin
                out_user_reg <= 2'b00;
                out_data_reg <= {in_port_reg, 128'd0};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_ipv6_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("IPv6 flag set on a failed result");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[127:0] == 128'd0)
        else $error("failed result carries a nonzero address");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && in_last_reg |=> out_valid_reg)
        else $error("terminator beat produced no result");
endmodule
`default_nettype wire

// File: bench/ip_address_text_parser_tb.sv
`default_nettype none
module ip_address_text_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ipp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        bit          ok;
        bit          v6;
        bit [63:0]   hi;
        bit [63:0]   lo;
        bit [15:0]   port;
    } addr_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [23:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic [1:0]   m_tuser;

    ip_address_text_parser dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    addr_result_t parsed_q[$];
    int  errors = 0;
    int  cycles = 0;
    int  texts_sent = 0;
    int  results_seen = 0;
    int  hold_cycles = 0;
    bit  no_idle = 0;
    bit  beat_taken = 0;

    bit [7:0]  v4_val;
    bit [1:0]  v4_dots;
    bit        v4_seen;
    bit        v4_fail;
    bit [7:0]  v4_oct[3];
    bit [15:0] grp_val;
    int        grp_dec;
    bit        grp_letter;
    int        grp_cnt;
    int        grp_done;
    int        grp_before;
    bit [15:0] grp_store[8];
    bit [5:0]  v6_fl;
    bit [7:0]  tl_val;
    bit [1:0]  tl_dots;
    bit        tl_seen;
    bit [7:0]  tl_oct[3];
    bit        v6_fail;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL ip_address_text_parser");
            $finish;
        end
    end

    function automatic void clear_parsers();
        v4_val = 0; v4_dots = 0; v4_seen = 0; v4_fail = 0;
        grp_val = 0; grp_dec = 0; grp_letter = 0; grp_cnt = 0;
        grp_done = 0; grp_before = 0; v6_fl = FL_RESET;
        tl_val = 0; tl_dots = 0; tl_seen = 0; v6_fail = 0;
        for (int i = 0; i < 3; i++) begin
            v4_oct[i] = 0;
            tl_oct[i] = 0;
        end
        for (int i = 0; i < 8; i++) grp_store[i] = 0;
    endfunction

    function automatic bit decimal_char(input bit [7:0] c, inout bit [7:0] v,
                                        inout bit [1:0] d, inout bit s,
                                        output bit wr, output bit [7:0] wv,
                                        output bit [1:0] wi);
        int t;
        wr = 0;
        wv = v;
        wi = d;
        if (c >= CH_0 && c <= CH_9) begin
            t = v * 10 + (c - CH_0);
            s = 1;
            if (t > 255) return 0;
            v = t[7:0];
            return 1;
        end
        if (c == CH_DOT) begin
            if (d == LAST_DOT) return 0;
            wr = 1;
            v = 0;
            d = d + 2'd1;
            s = 0;
            return 1;
        end
        return 0;
    endfunction

    function automatic void v6_update(input bit [7:0] c);
        int  nib;
        bit  wr;
        bit [7:0] wv;
        bit [1:0] wi;
        if (v6_fail) return;
        if (v6_fl[FL_TAIL]) begin
            if (!decimal_char(c, tl_val, tl_dots, tl_seen, wr, wv, wi)) v6_fail = 1;
            else if (wr) tl_oct[wi] = wv;
            return;
        end
        if (c >= CH_0 && c <= CH_9) nib = c - CH_0;
        else if (c >= CH_LA && c <= CH_LF) nib = c - LO_BASE;
        else if (c >= CH_UA && c <= CH_UF) nib = c - UP_BASE;
        else nib = 16;
        if (nib < 16) begin
            if (!v6_fl[FL_DIGIT] || grp_cnt >= 4) begin
                v6_fail = 1;
                return;
            end
            grp_cnt++;
            v6_fl[FL_COLON] = 1;
            v6_fl[FL_JUST] = 0;
            grp_val = {grp_val[11:0], nib[3:0]};
            if (c >= CH_0 && c <= CH_9) begin
                grp_dec = grp_dec * 10 + nib;
                if (grp_dec > 255) grp_dec = 256;
            end else begin
                grp_letter = 1;
            end
            return;
        end
        if (c == CH_COLON) begin
            if (!v6_fl[FL_COLON]) begin
                v6_fail = 1;
                return;
            end
            if (v6_fl[FL_JUST]) begin
                v6_fl[FL_DIGIT] = 1;
                v6_fl[FL_COLON] = 0;
                v6_fl[FL_ANOTHER] = 0;
                v6_fl[FL_DCOLON] = 0;
                grp_before = grp_done;
                return;
            end
            if (grp_done >= 8) begin
                v6_fail = 1;
                return;
            end
            if (grp_cnt == 0 && grp_done == 0) begin
                v6_fl[FL_COLON] = 1;
                v6_fl[FL_JUST] = 1;
                v6_fl[FL_ANOTHER] = 1;
                v6_fl[FL_DIGIT] = 0;
                return;
            end
            grp_store[grp_done] = grp_val;
            grp_done++;
            grp_val = 0; grp_dec = 0; grp_letter = 0; grp_cnt = 0;
            v6_fl[FL_COLON] = v6_fl[FL_DCOLON];
            v6_fl[FL_JUST] = 1;
            v6_fl[FL_ANOTHER] = 1;
            return;
        end
        if (c == CH_DOT) begin
            if (grp_done >= 7 || grp_letter || grp_dec > 255) begin
                v6_fail = 1;
                return;
            end
            tl_oct[0] = grp_dec[7:0];
            tl_dots = 1;
            tl_val = 0;
            tl_seen = 0;
            v6_fl[FL_TAIL] = 1;
            return;
        end
        v6_fail = 1;
    endfunction

    function automatic bit v6_close(output bit [63:0] hi, output bit [63:0] lo);
        bit [15:0] g[8];
        int after;
        hi = 0;
        lo = 0;
        if (v6_fail) return 0;
        if (v6_fl[FL_TAIL]) begin
            if (!tl_seen || tl_dots != LAST_DOT) return 0;
            grp_store[grp_done & 7] = {tl_oct[0], tl_oct[1]};
            grp_store[(grp_done + 1) & 7] = {tl_oct[2], tl_val};
            grp_done += 2;
            grp_cnt = 0;
            v6_fl[FL_ANOTHER] = 0;
        end
        if (grp_cnt > 0) begin
            if (grp_done >= 8) return 0;
            grp_store[grp_done] = grp_val;
            grp_done++;
        end else if (v6_fl[FL_ANOTHER]) begin
            return 0;
        end
        if (grp_done > 8) return 0;
        if (!v6_fl[FL_DCOLON]) begin
            if (grp_before > grp_done) return 0;
            after = grp_done - grp_before;
            for (int i = 0; i < 8; i++) begin
                if (i < grp_before) g[i] = grp_store[i];
                else if (i >= 8 - after) g[i] = grp_store[(grp_before + i - (8 - after)) & 7];
                else g[i] = 0;
            end
        end else if (grp_done == 8) begin
            for (int i = 0; i < 8; i++) g[i] = grp_store[i];
        end else begin
            return 0;
        end
        hi = {g[0], g[1], g[2], g[3]};
        lo = {g[4], g[5], g[6], g[7]};
        return 1;
    endfunction

    function automatic void predict_beat(input bit [7:0] c, input bit eot, input bit [15:0] port);
        addr_result_t r;
        bit wr;
        bit [7:0] wv;
        bit [1:0] wi;
        bit [63:0] hi;
        bit [63:0] lo;
        if (!eot) begin
            if (!v4_fail) begin
                if (!decimal_char(c, v4_val, v4_dots, v4_seen, wr, wv, wi)) v4_fail = 1;
                else if (wr) v4_oct[wi] = wv;
            end
            v6_update(c);
            return;
        end
        r = '{ok: 0, v6: 0, hi: 0, lo: 0, port: port};
        if (!v4_fail && v4_seen && v4_dots == LAST_DOT) begin
            r.ok = 1;
            r.lo = {32'd0, v4_oct[0], v4_oct[1], v4_oct[2], v4_val};
        end else if (v6_close(hi, lo)) begin
            r.ok = 1;
            r.v6 = 1;
            r.hi = hi;
            r.lo = lo;
        end
        parsed_q.push_back(r);
        clear_parsers();
    endfunction

    task automatic send_beat(input bit [7:0] c, input bit eot, input bit [15:0] port);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {port, c};
        s_tlast  <= eot;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        predict_beat(c, eot, port);
    endtask

    task automatic send_bytes(input bit [7:0] txt[$]);
        foreach (txt[i]) send_beat(txt[i], 1'b0, 16'($urandom));
        send_beat(8'($urandom), 1'b1, 16'($urandom));
        texts_sent++;
    endtask

    task automatic send_text(input string s);
        bit [7:0] txt[$];
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
        send_bytes(txt);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (parsed_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            if (m_tvalid && m_tready) begin
                beat_taken = 1;
                results_seen++;
                if (parsed_q.size() == 0) begin
                    $display("%0t: result with none expected, actual %h %h", $time,
                             m_tuser, m_tdata);
                    errors++;
                end else begin
                    addr_result_t e;
                    e = parsed_q.pop_front();
                    if (m_tuser[0] !== e.ok) begin
                        $display("%0t: parse_ok expected %0d actual %0d", $time, e.ok, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== e.v6) begin
                        $display("%0t: is_ipv6 expected %0d actual %0d", $time, e.v6, m_tuser[1]);
                        errors++;
                    end
                    if (m_tdata[63:0] !== e.hi) begin
                        $display("%0t: address_high expected %h actual %h", $time, e.hi,
                                 m_tdata[63:0]);
                        errors++;
                    end
                    if (m_tdata[127:64] !== e.lo) begin
                        $display("%0t: address_low expected %h actual %h", $time, e.lo,
                                 m_tdata[127:64]);
                        errors++;
                    end
                    if (m_tdata[143:128] !== e.port) begin
                        $display("%0t: port_out expected %h actual %h", $time, e.port,
                                 m_tdata[143:128]);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        int wait_left;
        wait_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (beat_taken) begin
                beat_taken = 0;
                wait_left = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (wait_left > 0) begin
                m_tready <= 1'b0;
                wait_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void add_hex_group(inout bit [7:0] txt[$]);
        string digits;
        int n;
        digits = "0123456789abcdefABCDEF";
        n = $urandom_range(1, 4);
        repeat (n) txt.push_back(digits[$urandom_range(0, 21)]);
    endfunction

    function automatic void add_decimal(inout bit [7:0] txt[$]);
        string s;
        case ($urandom_range(0, 3))
            0: s = $sformatf("%0d", $urandom_range(0, 9));
            1: s = $sformatf("%0d", $urandom_range(0, 255));
            2: s = $sformatf("%03d", $urandom_range(0, 255));
            default: s = $sformatf("%0d", $urandom_range(240, 299));
        endcase
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    endfunction

    function automatic void build_v4(inout bit [7:0] txt[$]);
        for (int i = 0; i < 4; i++) begin
            if (i > 0) txt.push_back(CH_DOT);
            if ($urandom_range(0, 15) != 0 || i == 3) add_decimal(txt);
        end
    endfunction

    function automatic void build_v6(inout bit [7:0] txt[$]);
        bit tail, gap;
        int total, lead, trail;
        tail  = $urandom_range(0, 3) == 0;
        gap   = $urandom_range(0, 1) == 1;
        total = tail ? 6 : 8;
        if (gap) begin
            lead  = $urandom_range(0, total - 1);
            trail = $urandom_range(0, total - 1 - lead);
        end else begin
            lead  = total;
            trail = 0;
        end
        for (int i = 0; i < lead; i++) begin
            if (i > 0) txt.push_back(CH_COLON);
            add_hex_group(txt);
        end
        if (gap) begin
            txt.push_back(CH_COLON);
            txt.push_back(CH_COLON);
        end
        for (int i = 0; i < trail; i++) begin
            if (i > 0) txt.push_back(CH_COLON);
            add_hex_group(txt);
        end
        if (tail) begin
            if (lead > 0 && !gap || trail > 0) txt.push_back(CH_COLON);
            build_v4(txt);
        end
        if (!gap && !tail && $urandom_range(0, 7) == 0) begin
            txt.push_back(CH_COLON);
            txt.push_back(CH_COLON);
        end
    endfunction

    task automatic test_ipv4_directed();
        send_text("0.0.0.0");
        send_text("255.255.255.255");
        send_text("001.020.003.199");
        send_text("256.1.1.1");
        send_text("1..2.3");
        send_text("1.2.3.");
        send_text("1.2.3.4.5");
        send_text("a.1.2.3");
    endtask

    task automatic test_ipv6_directed();
        send_text("::");
        send_text("::1");
        send_text("FFFF:ffff::");
        send_text("1:2:3:4:5:6:7:8");
        send_text("1:2:3:4:5:6:7:8::");
        send_text("12345::");
        send_text("1:::2");
        send_text(":1");
        send_text("::ffff:192.168.1.1");
        send_text("1:2:3:4:5:6:7:1.2.3.4");
        send_text("1:2:3:4:5:6:1.2.3.4");
        send_text("::1a.2.3.4");
        send_text("::1.2..4");
    endtask

    task automatic test_odd_chars();
        bit [7:0] txt[$];
        send_text("");
        txt = '{8'h31, CH_DOT, 8'h32, CH_DOT, 8'h33, CH_DOT, 8'h34, 8'h00};
        send_bytes(txt);
        send_text("g::");
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 300;
        no_idle = 1;
        repeat (4) send_text("10.0.0.1");
        send_text("::2");
        no_idle = 0;
        wait_drained();
    endtask

    task automatic test_random(input int count);
        bit [7:0] txt[$];
        for (int n = 0; n < count; n++) begin
            txt = {};
            no_idle = (n % 10) < 2;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: build_v4(txt);
                4, 5, 6, 7: build_v6(txt);
                default: repeat ($urandom_range(0, 8)) txt.push_back(8'($urandom));
            endcase
            if (txt.size() > 0 && $urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 2))
                    0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
                    1: txt[$urandom_range(0, txt.size() - 1)] = CH_COLON;
                    default: txt[$urandom_range(0, txt.size() - 1)] = CH_DOT;
                endcase
            end
            send_bytes(txt);
        end
        no_idle = 0;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        clear_parsers();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_ipv4_directed();
        test_ipv6_directed();
        test_odd_chars();
        test_backpressure();
        test_random(23);
        wait_drained();
        repeat (10) @(posedge aclk);
        $display("Ran %0d address texts with %0d results checked, IPv4, IPv6 and bad input.",
                 texts_sent, results_seen);
        $display("Both sides idled at random, with one long output stall and a full drain.");
        if (errors == 0 && parsed_q.size() == 0) begin
            $display("PASS ip_address_text_parser");
        end else begin
            $display("FAIL ip_address_text_parser");
        end
        $finish;
    end
endmodule
`default_nettype wire
